### src/bra_pkg.sv
// Shared types and codes for the bitmap run allocator.
// No dependencies; used by bra_cell and bitmap_run_allocator.
package bra_pkg;

   // Slot indexes never exceed 31, run bounds and counts fit in six bits.
   localparam int SLOT_W = 5;
   localparam int IDX_W  = 6;
   localparam int LEN_W  = 4;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;

   // Search wavefront handed from one cell to the next.
   typedef struct packed {
      logic             valid;
      logic [IDX_W-1:0] cnt;
   } bra_wave_type;

   // Broadcast mark command: set or clear every slot in [lo, hi).
   typedef struct packed {
      logic             set_en;
      logic             clr_en;
      logic [IDX_W-1:0] lo;
      logic [IDX_W-1:0] hi;
   } bra_mark_type;

endpackage

### src/bitmap_run_allocator.sv
// Top level of the first-fit bitmap run allocator: command port, scan control, cell row.
// Depends on bra_pkg and bra_cell.
//
//   channel   ports                                         transfer
//   request   start, busy, req_operation/run_length/slot    start && !busy
//   result    rsp_strobe, rsp_granted/granted_slot/offset   rsp_strobe, one cycle
//
// A free, or an allocate with an invalid length, answers in the cycle after its transfer.
// A valid allocate walks a wavefront along the cell row, one slot per cycle, and its
// result is registered when the wave finds a fitting run or passes the last slot.
// Reset clears the whole map at once. busy is high only while a scan runs; the
// receiver cannot stall, and a new request may be taken while a result is shown.
module bitmap_run_allocator import bra_pkg::*; #(
   parameter int SLOTS   = 32,
   parameter int MAX_RUN = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  logic              req_operation,
   input  logic [LEN_W-1:0]  req_run_length,
   input  logic [SLOT_W-1:0] req_slot_index,
   output logic              rsp_strobe,
   output logic              rsp_granted,
   output logic [SLOT_W-1:0] rsp_granted_slot,
   output logic [7:0]        rsp_byte_offset
);

   typedef enum logic {
      IDLE,
      SCAN
   } state_type;

   localparam logic [SLOT_W-1:0] LAST_POS = SLOT_W'(SLOTS - 1);
   localparam int               OFF_W    = SLOT_W + IDX_W;

   state_type         state_ff;
   logic [SLOT_W-1:0] pos_ff;
   logic [LEN_W-1:0]  len_ff;
   logic              rsp_strobe_ff;
   logic              rsp_granted_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic [7:0]        rsp_offset_ff;

   logic              accept;
   logic              len_ok;
   logic              hit_any;
   logic [SLOTS-1:0]  hit_vec;
   logic [IDX_W-1:0]  pos_next;
   logic [IDX_W-1:0]  run_start;
   logic [OFF_W-1:0]  offset_full;
   bra_mark_type      mark;
   bra_wave_type      wave [SLOTS+1];

   assign accept   = start && !busy;
   assign busy     = (state_ff == SCAN);
   assign len_ok   = (req_run_length != '0) &&
                     (IDX_W'(req_run_length) <= IDX_W'(MAX_RUN));
   assign hit_any  = |hit_vec;
   assign pos_next = IDX_W'(pos_ff) + IDX_W'(1);
   // The hit cell ends the run, so the run starts len-1 slots below it.
   assign run_start   = pos_next - IDX_W'(len_ff);
   assign offset_full = OFF_W'(run_start[SLOT_W-1:0]) * OFF_W'(MAX_RUN);

   always_comb begin
      mark = '0;
      if (accept && (req_operation == OP_FREE)) begin
         mark.clr_en = 1'b1;
         mark.lo     = IDX_W'(req_slot_index);
         mark.hi     = IDX_W'(req_slot_index) + IDX_W'(req_run_length);
      end else if (busy && hit_any) begin
         mark.set_en = 1'b1;
         mark.lo     = run_start;
         mark.hi     = pos_next;
      end
   end

   // The wave enters cell 0 in the first scan cycle with an empty free count.
   always_comb begin
      wave[0].valid = busy && (pos_ff == '0);
      wave[0].cnt   = '0;
   end

   for (genvar i = 0; i < SLOTS; i++) begin : g_cell
      bra_cell #(
         .INDEX(i)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .wave_in    (wave[i]),
         .run_length (len_ff),
         .mark       (mark),
         .hit        (hit_vec[i]),
         .wave_out   (wave[i+1])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         pos_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= 1'b0;
         unique case (state_ff)
            IDLE: begin
               if (accept) begin
                  len_ff <= req_run_length;
                  pos_ff <= '0;
                  if ((req_operation == OP_ALLOC) && len_ok) begin
                     state_ff <= SCAN;
                  end else begin
                     rsp_strobe_ff  <= 1'b1;
                     rsp_granted_ff <= (req_operation == OP_FREE);
                     rsp_slot_ff    <= '0;
                     rsp_offset_ff  <= '0;
                  end
               end
            end
            SCAN: begin
               if (hit_any) begin
                  state_ff       <= IDLE;
                  rsp_strobe_ff  <= 1'b1;
                  rsp_granted_ff <= 1'b1;
                  rsp_slot_ff    <= run_start[SLOT_W-1:0];
                  rsp_offset_ff  <= offset_full[7:0];
               end else if (pos_ff == LAST_POS) begin
                  state_ff       <= IDLE;
                  rsp_strobe_ff  <= 1'b1;
                  rsp_granted_ff <= 1'b0;
                  rsp_slot_ff    <= '0;
                  rsp_offset_ff  <= '0;
               end else begin
                  pos_ff <= pos_next[SLOT_W-1:0];
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe       = rsp_strobe_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_byte_offset  = rsp_offset_ff;

`ifndef SYNTHESIS
   // Only the cell under the wavefront may report a fitting run.
   a_single_hit: assert property (@(posedge clock) disable iff (reset)
      $onehot0(hit_vec))
      else $error("more than one cell reports a hit");

   // A wave that left the last cell means the scan reached the end of the map.
   a_wave_end: assert property (@(posedge clock) disable iff (reset)
      wave[SLOTS].valid |-> $past(busy) && ($past(pos_ff) == LAST_POS))
      else $error("wavefront out of step with the scan position");

   // A refused request carries no slot and no offset.
   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_granted |-> (rsp_granted_slot == '0) && (rsp_byte_offset == '0))
      else $error("refused result carries a slot");

   // A scan always ends in a result when it leaves the busy state.
   a_scan_result: assert property (@(posedge clock) disable iff (reset)
      busy && (hit_any || (pos_ff == LAST_POS)) |=> rsp_strobe && !busy)
      else $error("scan ended without a result");
`endif

endmodule

### src/bra_cell.sv
// One slot of the allocator map: holds the used bit and passes the search wave on.
// Depends on bra_pkg.
module bra_cell import bra_pkg::*; #(
   parameter int INDEX = 0
) (
   input  logic             clock,
   input  logic             reset,
   input  bra_wave_type     wave_in,
   input  logic [LEN_W-1:0] run_length,
   input  bra_mark_type     mark,
   output logic             hit,
   output bra_wave_type     wave_out
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic             used_ff;
   logic             used_in;
   bra_wave_type     wave_ff;
   bra_wave_type     wave_in_next;
   logic [IDX_W-1:0] cnt_here;
   logic             in_run;

   // The count is the number of free slots ending at this one.
   assign cnt_here = used_ff ? '0 : wave_in.cnt + IDX_W'(1);
   assign hit      = wave_in.valid && (cnt_here >= IDX_W'(run_length));
   assign in_run   = (MY_INDEX >= mark.lo) && (MY_INDEX < mark.hi);

   always_comb begin
      wave_in_next.valid = wave_in.valid && !hit;
      wave_in_next.cnt   = cnt_here;
      used_in = used_ff;
      if (mark.set_en && in_run) begin
         used_in = 1'b1;
      end
      if (mark.clr_en && in_run) begin
         used_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff       <= 1'b0;
         wave_ff.valid <= 1'b0;
      end else begin
         used_ff       <= used_in;
         wave_ff.valid <= wave_in_next.valid;
      end
      wave_ff.cnt <= wave_in_next.cnt;
   end

   assign wave_out = wave_ff;

endmodule
